@@ rtl/core/pss_pkg.sv @@
// Shared widths, request codes and status codes for the positional sequence store.
`timescale 1ns / 1ps

package pss_pkg;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 5;

    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_AT    = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOTHING = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

endpackage

@@ rtl/core/pss_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module pss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/positional_sequence_store_core.sv @@
// Top level of the positional sequence store: request sequencer around one shared RAM.
`timescale 1ns / 1ps

// The block keeps an ordered list of up to DEPTH signed 32-bit values in a RAM.
// A request is taken at a rising edge where start is high and busy is low; it
// carries a mode, a value and an index. Busy stays high until the result has
// been shown. The result (status, length, front and back values) is on the
// output ports for exactly one cycle, marked by o_done, and the receiver must
// take it then, since it cannot hold results off.
// A request that opens or closes a gap moves the entries between the gap and
// the end of the list through the single RAM port pair, one entry per cycle;
// every request then reads the front and the back. A shifting insert passes
// S_SHIFT, S_DRAIN and S_PLACE, a shifting delete S_SHIFT and S_DRAIN, and
// an append S_PLACE, before S_RD_FRONT, S_RD_BACK and S_REPLY. The
// next request can be taken in the cycle o_done is high. The rate is set by
// the one RAM read port.
// Reset (synchronous, active low) empties the list and clears the sequencer;
// no clearing pass is needed because only written entries are ever read.
// Lengths wrap in the 5-bit length field when DEPTH exceeds 31.

module positional_sequence_store_core #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pss_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [pss_pkg::VALUE_W-1:0]  i_item_value,
    input  logic [pss_pkg::INDEX_W-1:0]         i_item_index,
    output logic                                o_done,
    output logic [pss_pkg::STATUS_W-1:0]        o_status,
    output logic [pss_pkg::LENGTH_W-1:0]        o_length,
    output logic signed [pss_pkg::VALUE_W-1:0]  o_front_value,
    output logic signed [pss_pkg::VALUE_W-1:0]  o_back_value
);

    import pss_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PLACE,
        S_RD_FRONT,
        S_RD_BACK,
        S_REPLY
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_ptr, n_ptr;
    logic                  r_up, n_up;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_wp_valid, n_wp_valid;
    logic [AW-1:0]         r_wp_addr, n_wp_addr;
    logic [VALUE_W-1:0]    r_front, n_front;
    logic                  r_done, n_done;
    logic [STATUS_W-1:0]   r_o_status, n_o_status;
    logic [LENGTH_W-1:0]   r_o_length, n_o_length;
    logic [VALUE_W-1:0]    r_o_front, n_o_front;
    logic [VALUE_W-1:0]    r_o_back, n_o_back;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_W-1:0]    ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_W-1:0]    ram_rdata;

    logic [CMPW-1:0]       idx_ext;
    logic [CMPW-1:0]       cnt_ext;
    logic                  idx_in_list;
    logic [CW-1:0]         count_m1;
    logic [CW-1:0]         ptr_inc;
    logic [CW-1:0]         ptr_dec;
    logic [CW-1:0]         ins_pos;
    logic [CW-1:0]         del_pos;
    logic [CW-1:0]         del_pos_p1;

    assign idx_ext     = CMPW'(i_item_index);
    assign cnt_ext     = CMPW'(r_count);
    assign idx_in_list = (idx_ext < cnt_ext);
    assign count_m1    = r_count - 1'b1;
    assign ptr_inc     = r_ptr + 1'b1;
    assign ptr_dec     = r_ptr - 1'b1;
    assign del_pos_p1  = del_pos + 1'b1;

    always_comb begin
        ins_pos = r_count;
        del_pos = '0;
        unique case (i_mode)
            MODE_INS_FRONT: ins_pos = '0;
            MODE_INS_BACK:  ins_pos = r_count;
            MODE_INS_AT:    ins_pos = idx_in_list ? CW'(idx_ext) : r_count;
            MODE_DEL_FRONT: del_pos = '0;
            MODE_DEL_BACK:  del_pos = count_m1;
            MODE_DEL_AT:    del_pos = CW'(idx_ext);
            default: begin
                ins_pos = r_count;
                del_pos = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_ptr      = r_ptr;
        n_up       = r_up;
        n_value    = r_value;
        n_status   = r_status;
        n_wp_valid = r_wp_valid;
        n_wp_addr  = r_wp_addr;
        n_front    = r_front;
        n_done     = 1'b0;
        n_o_status = r_o_status;
        n_o_length = r_o_length;
        n_o_front  = r_o_front;
        n_o_back   = r_o_back;
        ram_we     = 1'b0;
        ram_waddr  = r_wp_addr;
        ram_wdata  = ram_rdata;
        ram_raddr  = r_ptr[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status   = STAT_DONE;
                    n_value    = i_item_value;
                    n_wp_valid = 1'b0;
                    n_state    = S_RD_FRONT;
                    case (i_mode) inside
                        MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_pos = ins_pos;
                                n_up  = 1'b1;
                                if (ins_pos != r_count) begin
                                    n_ptr   = count_m1;
                                    n_state = S_SHIFT;
                                end else begin
                                    n_state = S_PLACE;
                                end
                            end
                        end
                        MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                            if (r_count == '0 || (i_mode == MODE_DEL_AT && !idx_in_list)) begin
                                n_status = STAT_NOTHING;
                            end else if (del_pos_p1 == r_count) begin
                                n_count = count_m1;
                            end else begin
                                n_up    = 1'b0;
                                n_ptr   = del_pos_p1;
                                n_pos   = count_m1;
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_status = STAT_DONE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                ram_raddr  = r_ptr[AW-1:0];
                ram_we     = r_wp_valid;
                n_wp_valid = 1'b1;
                n_wp_addr  = r_up ? ptr_inc[AW-1:0] : ptr_dec[AW-1:0];
                n_ptr      = r_up ? ptr_dec : ptr_inc;
                if (r_ptr == r_pos) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                ram_we     = 1'b1;
                n_wp_valid = 1'b0;
                if (r_up) begin
                    n_state = S_PLACE;
                end else begin
                    n_count = count_m1;
                    n_state = S_RD_FRONT;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = r_value;
                n_count   = r_count + 1'b1;
                n_state   = S_RD_FRONT;
            end
            S_RD_FRONT: begin
                ram_raddr = '0;
                n_state   = S_RD_BACK;
            end
            S_RD_BACK: begin
                ram_raddr = count_m1[AW-1:0];
                n_front   = ram_rdata;
                n_state   = S_REPLY;
            end
            S_REPLY: begin
                n_done     = 1'b1;
                n_o_status = r_status;
                n_o_length = LENGTH_W'(r_count);
                if (r_count == '0) begin
                    n_o_front = '0;
                    n_o_back  = '0;
                end else begin
                    n_o_front = r_front;
                    n_o_back  = ram_rdata;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_wp_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_wp_valid <= n_wp_valid;
            r_done     <= n_done;
        end
        r_pos      <= n_pos;
        r_ptr      <= n_ptr;
        r_up       <= n_up;
        r_value    <= n_value;
        r_status   <= n_status;
        r_wp_addr  <= n_wp_addr;
        r_front    <= n_front;
        r_o_status <= n_o_status;
        r_o_length <= n_o_length;
        r_o_front  <= n_o_front;
        r_o_back   <= n_o_back;
    end

    pss_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_o_status;
    assign o_length      = r_o_length;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;

endmodule
